@@ src/dense_layer_mac_core_macros.svh @@
// Assertion macros for the dense layer MAC core checker
`ifndef DENSE_LAYER_MAC_CORE_MACROS_SVH
`define DENSE_LAYER_MAC_CORE_MACROS_SVH

// same-cycle implication, skipped during reset
`define DLM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, skipped during reset
`define DLM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/dlm_pkg.sv @@
// Shared types and constants of the dense layer MAC core
package dlm_pkg;

  localparam int DefMaxIn    = 64;
  localparam int DefMaxOut   = 64;
  localparam int DefFracBits = 12;

  localparam int DataW = 16;
  localparam int IdxW  = 12;
  localparam int OutIdxW = 6;
  localparam int CfgW  = 7;

  typedef enum logic [1:0] {
    FUNC_WEIGHT = 2'd0,
    FUNC_BIAS   = 2'd1,
    FUNC_PUSH   = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    REG_IN_COUNT  = 2'd0,
    REG_OUT_COUNT = 2'd1,
    REG_USE_BIAS  = 2'd2,
    REG_NONE      = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SLOT,
    ST_ISSUE,
    ST_DRAIN
  } seq_state_t;

  typedef struct packed {
    logic               valid;
    logic               first;
    logic               lastin;
    logic               lastout;
    logic [OutIdxW-1:0] oidx;
  } mac_ctl_t;

endpackage

@@ src/dlm_cell.sv @@
// One cell of the row ring: holds one input element
module dlm_cell import dlm_pkg::*; (
  input  logic             clk,
  input  logic             load,
  input  logic             shift,
  input  logic [DataW-1:0] d_load,
  input  logic [DataW-1:0] d_shift,
  output logic [DataW-1:0] q
);

  always_ff @(posedge clk) begin
    if (load) begin
      q <= d_load;
    end else if (shift) begin
      q <= d_shift;
    end
  end

endmodule

@@ src/dlm_mac.sv @@
// Multiply-accumulate pipeline with rounding, saturation and output register
module dlm_mac import dlm_pkg::*; #(
  parameter int MAX_IN    = DefMaxIn,
  parameter int FRAC_BITS = DefFracBits
) (
  input  logic                clk,
  input  logic                rst,
  input  mac_ctl_t            ctl,
  input  logic [DataW-1:0]    w,
  input  logic [DataW-1:0]    x,
  input  logic [DataW-1:0]    b,
  input  logic                use_bias,
  input  logic                out_stall,
  output logic                out_valid,
  output logic [OutIdxW-1:0]  out_index,
  output logic [DataW-1:0]    result,
  output logic                saturated,
  output logic                last,
  output logic                done
);

  localparam int AccW = 2 * DataW + $clog2(MAX_IN) + 1;
  localparam int RndW = AccW + 1;

  mac_ctl_t                 ctl2, ctl3;
  logic signed [2*DataW-1:0] prod;
  logic signed [AccW-1:0]   bterm;
  logic signed [AccW-1:0]   acc;
  logic signed [RndW-1:0]   rnd;
  logic signed [RndW-1:0]   shr;
  logic [DataW-1:0]         res_next;
  logic                     sat_next;

  always_ff @(posedge clk) begin
    prod  <= $signed(w) * $signed(x);
    bterm <= use_bias ? (AccW'($signed(b)) <<< FRAC_BITS) : '0;
    if (ctl2.valid) begin
      acc <= (ctl2.first ? bterm : acc) + AccW'(prod);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl2 <= '0;
      ctl3 <= '0;
    end else begin
      ctl2 <= ctl;
      ctl3 <= ctl2;
    end
  end

  always_comb begin
    rnd = RndW'(acc);
    if (FRAC_BITS > 0) begin
      rnd = rnd + (RndW'(1) <<< (FRAC_BITS > 0 ? FRAC_BITS - 1 : 0));
    end
    shr = rnd >>> FRAC_BITS;
    sat_next = 1'b1;
    if (shr > $signed(RndW'(32767))) begin
      res_next = 16'h7fff;
    end else if (shr < -$signed(RndW'(32768))) begin
      res_next = 16'h8000;
    end else begin
      res_next = shr[DataW-1:0];
      sat_next = 1'b0;
    end
  end

  assign done = ctl3.valid && ctl3.lastin;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      result    <= res_next;
      saturated <= sat_next;
      out_index <= ctl3.oidx;
      last      <= ctl3.lastout;
    end
  end

endmodule

@@ src/dense_layer_mac_core.sv @@
// Top level of the dense layer MAC core
//
//  channel  | signals                                  | flow
//  ---------+------------------------------------------+---------------------
//  input    | in_valid in_stall func index value        | weight/bias/element
//  output   | out_valid out_stall out_index result ...  | one result per output
//  config   | cfg_valid cfg_ready cfg_index cfg_data    | register writes
//
// Loads and non-final pushes do not stall the input. The push that ends a row
// starts out_count passes, each reading in_count weights from the single
// weight port, and a pass waits for the previous result to leave.
// in_stall is high for the whole row computation. Reset is synchronous.
module dense_layer_mac_core import dlm_pkg::*; #(
  parameter int MAX_IN    = DefMaxIn,
  parameter int MAX_OUT   = DefMaxOut,
  parameter int FRAC_BITS = DefFracBits
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         func,
  input  logic [IdxW-1:0]    index,
  input  logic [DataW-1:0]   value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [OutIdxW-1:0] out_index,
  output logic [DataW-1:0]   result,
  output logic               saturated,
  output logic               last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [CfgW-1:0]    cfg_data
);

  localparam int WDepth = MAX_IN * MAX_OUT;
  localparam int WaW    = (WDepth > 1) ? $clog2(WDepth) : 1;
  localparam int InW    = $clog2(MAX_IN + 1);
  localparam int OW     = (MAX_OUT > 1) ? $clog2(MAX_OUT) : 1;
  localparam int NoW    = $clog2(MAX_OUT + 1);

  logic [CfgW-1:0] in_count, out_count;
  logic            use_bias;

  logic [DataW-1:0] wmem [WDepth];
  logic [DataW-1:0] bmem [MAX_OUT];
  logic [DataW-1:0] w_rd, b_rd, x_rd;
  logic [DataW-1:0] ring [MAX_IN];

  seq_state_t state, state_next;
  logic [InW-1:0] count, n_in, step_i;
  logic [NoW-1:0] n_out;
  logic [OutIdxW-1:0] oidx;
  logic [WaW-1:0] base, rd_addr;
  logic accept, push, row_done, step, mac_done;
  mac_ctl_t ctl0, ctl1;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign push      = accept && (func_t'(func) == FUNC_PUSH);
  assign row_done  = push && ((count + InW'(1)) >= n_in);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_count  <= CfgW'(64);
      out_count <= CfgW'(64);
      use_bias  <= 1'b1;
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_IN_COUNT:  in_count  <= cfg_data;
        REG_OUT_COUNT: out_count <= cfg_data;
        REG_USE_BIAS:  use_bias  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (in_count == '0) begin
      n_in = InW'(1);
    end else if (int'(in_count) > MAX_IN) begin
      n_in = InW'(MAX_IN);
    end else begin
      n_in = InW'(in_count);
    end
    if (out_count == '0) begin
      n_out = NoW'(1);
    end else if (int'(out_count) > MAX_OUT) begin
      n_out = NoW'(MAX_OUT);
    end else begin
      n_out = NoW'(out_count);
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (func_t'(func) == FUNC_WEIGHT) && (int'(index) < WDepth)) begin
      wmem[WaW'(index)] <= value;
    end
    if (accept && (func_t'(func) == FUNC_BIAS) && (int'(index) < MAX_OUT)) begin
      bmem[OW'(index)] <= value;
    end
    w_rd <= wmem[rd_addr];
    b_rd <= bmem[OW'(oidx)];
    x_rd <= ring[0];
  end

  for (genvar k = 0; k < MAX_IN; k++) begin : g_cell
    logic ld, sh;
    assign ld = push && (count == InW'(k));
    assign sh = step && (InW'(k) < n_in);
    dlm_cell u_cell (
      .clk     (clk),
      .load    (ld),
      .shift   (sh),
      .d_load  (value),
      .d_shift ((InW'(k) == n_in - InW'(1)) ? ring[0] : ring[(k + 1) % MAX_IN]),
      .q       (ring[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      ctl1  <= '0;
    end else begin
      state <= state_next;
      ctl1  <= ctl0;
      if (push) begin
        count <= row_done ? '0 : count + InW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (row_done) begin
      oidx   <= '0;
      base   <= '0;
      step_i <= '0;
    end
    if (state == ST_SLOT) begin
      rd_addr <= base;
    end
    if (step) begin
      rd_addr <= rd_addr + WaW'(1);
      step_i  <= (step_i == n_in - InW'(1)) ? '0 : step_i + InW'(1);
    end
    if (state == ST_DRAIN && mac_done) begin
      oidx <= oidx + OutIdxW'(1);
      base <= base + WaW'(MAX_IN);
    end
  end

  always_comb begin
    state_next   = state;
    step         = 1'b0;
    ctl0         = '0;
    ctl0.oidx    = oidx;
    ctl0.first   = (step_i == '0);
    ctl0.lastin  = (step_i == n_in - InW'(1));
    ctl0.lastout = (NoW'(oidx) == n_out - NoW'(1));
    unique case (state)
      ST_IDLE: begin
        if (row_done) begin
          state_next = ST_SLOT;
        end
      end
      ST_SLOT: begin
        if (!out_valid) begin
          state_next = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        step       = 1'b1;
        ctl0.valid = 1'b1;
        if (ctl0.lastin) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (mac_done) begin
          state_next = ctl0.lastout ? ST_IDLE : ST_SLOT;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  dlm_mac #(
    .MAX_IN    (MAX_IN),
    .FRAC_BITS (FRAC_BITS)
  ) u_mac (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl1),
    .w         (w_rd),
    .x         (x_rd),
    .b         (b_rd),
    .use_bias  (use_bias),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_index (out_index),
    .result    (result),
    .saturated (saturated),
    .last      (last),
    .done      (mac_done)
  );

endmodule

@@ src/dlm_checker.sv @@
// Port-level checker for the dense layer MAC core and its bind
`include "dense_layer_mac_core_macros.svh"

module dlm_checker import dlm_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic [DataW-1:0] result,
  input logic             last
);

  `DLM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(result), "stalled result changed")
  `DLM_ASSERT_NEXT(a_last_gap, out_valid && !out_stall && last, !out_valid, "request after last result")
  `DLM_ASSERT_NEXT(a_idle_quiet, !out_valid && !in_stall, !out_valid, "result without row computation")
  `DLM_ASSERT_NOW(a_busy_last, out_valid && !in_stall, last, "non-final result while idle")

endmodule

bind dense_layer_mac_core dlm_checker u_dlm_checker (.*);
